// File: sv/tnrc_pkg.sv
// Package for the tilemap neighbor-reference codec.
// Holds screen sizes, code values and the result item type; no dependencies.
package tnrc_pkg;

    localparam int ROW_WIDTH    = 16;
    localparam int ROW_COUNT    = 13;
    localparam int HIST_DEPTH   = ROW_WIDTH + 1;
    localparam int SCREEN_TILES = ROW_WIDTH * ROW_COUNT;
    localparam int POS_W        = $clog2(SCREEN_TILES + HIST_DEPTH);
    localparam int TILE_W       = 8;
    localparam int CODE_W       = 2;

    localparam logic [CODE_W-1:0] CODE_LEFT       = 2'b00;
    localparam logic [CODE_W-1:0] CODE_ABOVE      = 2'b01;
    localparam logic [CODE_W-1:0] CODE_ABOVE_LEFT = 2'b10;
    localparam logic [CODE_W-1:0] CODE_LITERAL    = 2'b11;

    typedef logic [TILE_W-1:0] tile_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef struct packed {
        tile_t tile;
        code_t code;
        tile_t literal;
        logic  literal_present;
        logic  last_of_screen;
        logic  bad_reference;
    } result_t;

    typedef struct packed {
        tile_t left;
        tile_t above;
        tile_t above_left;
    } taps_t;

endpackage

// File: sv/tnrc_cell.sv
// One history cell: holds a tile byte and passes it to the next cell.
// Depends on tnrc_pkg.
module tnrc_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  tnrc_pkg::tile_t din,
    output tnrc_pkg::tile_t dout
);
    import tnrc_pkg::*;

    tile_t tile_reg;
    tile_t tile_next;

    always_comb
    begin
        tile_next = shift ? din : tile_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_reg <= '0;
        end
        else
        begin
            tile_reg <= tile_next;
        end
    end

    assign dout = tile_reg;

endmodule

// File: sv/tnrc_chain.sv
// Row of history cells, newest tile first, with the left, above and
// above-left taps. Depends on tnrc_pkg and tnrc_cell.
module tnrc_chain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  tnrc_pkg::tile_t tile_new,
    output tnrc_pkg::taps_t taps
);
    import tnrc_pkg::*;

    tile_t q [HIST_DEPTH];

    genvar i;
    generate
        for (i = 0; i < HIST_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                tnrc_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (tile_new),
                    .dout  (q[i])
                );
            end
            else
            begin : g_body
                tnrc_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (q[i-1]),
                    .dout  (q[i])
                );
            end
        end
    endgenerate

    assign taps.left       = q[0];
    assign taps.above      = q[ROW_WIDTH-1];
    assign taps.above_left = q[HIST_DEPTH-1];

endmodule

// File: sv/tilemap_neighbor_reference_codec.sv
// Top level of the tilemap neighbor-reference codec: mode register, screen
// position, code selection and output register with skid. Uses tnrc_pkg, tnrc_chain.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_stall | tile_in, code_in, literal_in
//   out     | out_valid/out_stall | tile_out, code_out, literal_out,
//           |                     | literal_present, last_of_screen, bad_reference
//   cfg     | cfg_write           | cfg_data (encode_mode)
//
// One item per cycle while in_stall is low; each result is registered before output.
// The history chain shifts in the same cycle, so the next item sees it at once.
// Reset clears the mode, the position and the history; no clearing pass.
// A stalled output holds in the output register; one more item goes to the
// skid register, and in_stall rises only while the skid register is full.
module tilemap_neighbor_reference_codec (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic            cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  tnrc_pkg::tile_t tile_in,
    input  tnrc_pkg::code_t code_in,
    input  tnrc_pkg::tile_t literal_in,
    output logic            out_valid,
    input  logic            out_stall,
    output tnrc_pkg::tile_t tile_out,
    output tnrc_pkg::code_t code_out,
    output tnrc_pkg::tile_t literal_out,
    output logic            literal_present,
    output logic            last_of_screen,
    output logic            bad_reference
);
    import tnrc_pkg::*;

    logic    encode_mode_reg;
    logic    encode_mode_next;
    pos_t    pos_reg;
    pos_t    pos_next;
    result_t main_reg;
    result_t main_next;
    logic    main_valid_reg;
    logic    main_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    taps_t   taps;
    result_t res;
    logic    accept;
    logic    take;
    logic    ok_left;
    logic    ok_above;
    logic    ok_above_left;

    assign accept = in_valid & ~skid_valid_reg;
    assign take   = main_valid_reg & ~out_stall;

    tnrc_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (accept),
        .tile_new (res.tile),
        .taps     (taps)
    );

    assign ok_left       = pos_reg >= POS_W'(1);
    assign ok_above      = pos_reg >= POS_W'(ROW_WIDTH);
    assign ok_above_left = pos_reg >= POS_W'(HIST_DEPTH);

    always_comb
    begin
        res                 = '0;
        res.last_of_screen  = (pos_reg == POS_W'(SCREEN_TILES - 1));
        if (encode_mode_reg)
        begin
            res.tile = tile_in;
            if (ok_left && tile_in == taps.left)
            begin
                res.code = CODE_LEFT;
            end
            else if (ok_above && tile_in == taps.above)
            begin
                res.code = CODE_ABOVE;
            end
            else if (ok_above_left && tile_in == taps.above_left)
            begin
                res.code = CODE_ABOVE_LEFT;
            end
            else
            begin
                res.code    = CODE_LITERAL;
                res.literal = tile_in;
            end
        end
        else
        begin
            res.code = code_in;
            unique case (code_in)
                CODE_LEFT:
                begin
                    res.tile          = ok_left ? taps.left : '0;
                    res.bad_reference = ~ok_left;
                end
                CODE_ABOVE:
                begin
                    res.tile          = ok_above ? taps.above : '0;
                    res.bad_reference = ~ok_above;
                end
                CODE_ABOVE_LEFT:
                begin
                    res.tile          = ok_above_left ? taps.above_left : '0;
                    res.bad_reference = ~ok_above_left;
                end
                default:
                begin
                    res.tile    = literal_in;
                    res.literal = literal_in;
                end
            endcase
        end
        res.literal_present = (res.code == CODE_LITERAL);
    end

    always_comb
    begin
        encode_mode_next = cfg_write ? cfg_data : encode_mode_reg;
        pos_next         = pos_reg;
        if (accept)
        begin
            pos_next = res.last_of_screen ? '0 : pos_reg + POS_W'(1);
        end

        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = res;
                main_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encode_mode_reg <= 1'b0;
            pos_reg         <= '0;
            main_valid_reg  <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            encode_mode_reg <= encode_mode_next;
            pos_reg         <= pos_next;
            main_valid_reg  <= main_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_stall        = skid_valid_reg;
    assign out_valid       = main_valid_reg;
    assign tile_out        = main_reg.tile;
    assign code_out        = main_reg.code;
    assign literal_out     = main_reg.literal;
    assign literal_present = main_reg.literal_present;
    assign last_of_screen  = main_reg.last_of_screen;
    assign bad_reference   = main_reg.bad_reference;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register full while output register empty");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(SCREEN_TILES))
        else $error("screen position out of range");

    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.last_of_screen |=> pos_reg == '0)
        else $error("screen position did not wrap after last tile");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_reference |-> tile_out == '0 && !literal_present)
        else $error("bad reference with nonzero tile or literal");

endmodule
